// ===== rtl/dss_pkg.sv =====
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants for the decimal stream summer
// Operation codes, queue sizing and the widths of the sum and its decimal form.
// ----------------------------------------------------------------------------
package dss_pkg;

  // Width of the running sum and of the number being built
  localparam int VALUE_WIDTH = 32;
  // Decimal digits needed for 2^VALUE_WIDTH - 1 (1233/4096 ~ log10(2))
  localparam int NUM_DIGITS  = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int BCD_W       = 4 * NUM_DIGITS;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);
  localparam int IDX_W       = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

  // Command queue between front and back
  localparam int QDEPTH = 4;
  localparam int Q_AW   = $clog2(QDEPTH);

  // Input function codes
  localparam logic [1:0] FUNC_DATA = 2'd0;
  localparam logic [1:0] FUNC_EOW  = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // Characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    OP_DIGIT,
    OP_MINUS,
    OP_SEP,
    OP_BAD,
    OP_EOW,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CONV,
    B_SIGN,
    B_DIGITS
  } bstate_t;

endpackage

// ===== rtl/dss_front.sv =====
// ----------------------------------------------------------------------------
// dss_front: input classifier
// Turns each accepted transaction with a defined function code into a command for the back end.
// ----------------------------------------------------------------------------
module dss_front (
  input  logic              push,
  input  logic              q_full,
  input  logic [1:0]        func,
  input  logic [7:0]        byte_in,
  output logic              q_push,
  output dss_pkg::cmd_t     cmd
);

  logic accept;
  assign accept = push && !q_full;

  always_comb begin
    cmd.digit = byte_in[3:0];
    cmd.op    = dss_pkg::OP_BAD;
    q_push    = 1'b0;
    unique case (func)
      dss_pkg::FUNC_DATA: begin
        q_push = accept;
        if (byte_in == dss_pkg::CH_MINUS) begin
          cmd.op = dss_pkg::OP_MINUS;
        end else if (byte_in >= dss_pkg::CH_ZERO && byte_in <= dss_pkg::CH_NINE) begin
          cmd.op = dss_pkg::OP_DIGIT;
        end else if (byte_in == dss_pkg::CH_NUL || byte_in == dss_pkg::CH_SPACE ||
                     byte_in == dss_pkg::CH_NL) begin
          cmd.op = dss_pkg::OP_SEP;
        end else begin
          cmd.op = dss_pkg::OP_BAD;
        end
      end
      dss_pkg::FUNC_EOW: begin
        q_push = accept;
        cmd.op = dss_pkg::OP_EOW;
      end
      dss_pkg::FUNC_READ: begin
        q_push = accept;
        cmd.op = dss_pkg::OP_READ;
      end
      default: begin
        // undefined function: drop
        q_push = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/dss_queue.sv =====
// ----------------------------------------------------------------------------
// dss_queue: command queue
// Small first-in first-out store between the classifier and the back end.
// ----------------------------------------------------------------------------
module dss_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  dss_pkg::cmd_t     wr_cmd,
  input  logic              rd,
  output dss_pkg::cmd_t     rd_cmd,
  output logic              q_full,
  output logic              q_empty
);

  dss_pkg::cmd_t          mem [dss_pkg::QDEPTH];
  logic [dss_pkg::Q_AW-1:0] wptr;
  logic [dss_pkg::Q_AW-1:0] rptr;
  logic [dss_pkg::Q_AW:0]   count;

  assign q_full  = (count == (dss_pkg::Q_AW+1)'(dss_pkg::QDEPTH));
  assign q_empty = (count == '0);
  assign rd_cmd  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/dss_back.sv =====
// ----------------------------------------------------------------------------
// dss_back: parser state, accumulator and decimal formatter
// Executes queued commands; converts the sum by shift-and-add-3 on reads that return it.
// ----------------------------------------------------------------------------
module dss_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  dss_pkg::cmd_t     q_cmd,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output logic [7:0]        out_char,
  output logic              last,
  output logic              empty_res
);

  localparam int W = dss_pkg::VALUE_WIDTH;
  localparam int B = dss_pkg::BCD_W;

  dss_pkg::bstate_t state, state_next;

  logic [W-1:0] running_sum, running_sum_next;
  logic [W-1:0] number_value, number_value_next;
  logic         negative_flag, negative_flag_next;
  logic         in_number, in_number_next;
  logic         discarding, discarding_next;
  logic         already_sent, already_sent_next;

  logic [W-1:0]              mag, mag_next;
  logic [B-1:0]              bcd, bcd_next;
  logic                      sum_neg, sum_neg_next;
  logic [dss_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [dss_pkg::IDX_W-1:0] idx, idx_next;
  logic                      started, started_next;

  logic       out_valid, out_valid_next;
  logic [7:0] out_char_next;
  logic       last_next, empty_res_next;

  logic         out_free;
  logic [W-1:0] addend;
  logic [W-1:0] sum_closed;
  logic [W-1:0] digit_acc;
  logic [B-1:0] bcd_adj;
  logic [3:0]   top_digit;
  logic         last_digit;

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;

  // Value added when the current number closes
  assign addend     = negative_flag ? (~number_value + 1'b1) : number_value;
  assign sum_closed = running_sum + addend;
  assign digit_acc  = (number_value << 3) + (number_value << 1) + W'(q_cmd.digit);

  // Add 3 to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < dss_pkg::NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  assign top_digit  = bcd[B-1 -: 4];
  assign last_digit = (idx == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dss_pkg::B_IDLE;
      running_sum   <= '0;
      number_value  <= '0;
      negative_flag <= 1'b0;
      in_number     <= 1'b0;
      discarding    <= 1'b0;
      already_sent  <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      running_sum   <= running_sum_next;
      number_value  <= number_value_next;
      negative_flag <= negative_flag_next;
      in_number     <= in_number_next;
      discarding    <= discarding_next;
      already_sent  <= already_sent_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    mag       <= mag_next;
    bcd       <= bcd_next;
    sum_neg   <= sum_neg_next;
    cnt       <= cnt_next;
    idx       <= idx_next;
    started   <= started_next;
    out_char  <= out_char_next;
    last      <= last_next;
    empty_res <= empty_res_next;
  end

  always_comb begin
    state_next         = state;
    running_sum_next   = running_sum;
    number_value_next  = number_value;
    negative_flag_next = negative_flag;
    in_number_next     = in_number;
    discarding_next    = discarding;
    already_sent_next  = already_sent;
    mag_next           = mag;
    bcd_next           = bcd;
    sum_neg_next       = sum_neg;
    cnt_next           = cnt;
    idx_next           = idx;
    started_next       = started;
    out_valid_next     = out_valid && !pop;
    out_char_next      = out_char;
    last_next          = last;
    empty_res_next     = empty_res;
    q_pop              = 1'b0;

    unique case (state)
      dss_pkg::B_IDLE: begin
        if (!q_empty) begin
          unique case (q_cmd.op)
            dss_pkg::OP_READ: begin
              if (already_sent) begin
                if (out_free) begin
                  q_pop             = 1'b1;
                  already_sent_next = 1'b0;
                  out_valid_next    = 1'b1;
                  out_char_next     = 8'h00;
                  last_next         = 1'b1;
                  empty_res_next    = 1'b1;
                end
              end else begin
                q_pop        = 1'b1;
                sum_neg_next = running_sum[W-1];
                mag_next     = running_sum[W-1] ? (~running_sum + 1'b1) : running_sum;
                bcd_next     = '0;
                cnt_next     = '0;
                state_next   = dss_pkg::B_CONV;
              end
            end
            dss_pkg::OP_EOW: begin
              q_pop              = 1'b1;
              running_sum_next   = sum_closed;
              number_value_next  = '0;
              negative_flag_next = 1'b0;
              in_number_next     = 1'b0;
              discarding_next    = 1'b0;
            end
            dss_pkg::OP_SEP: begin
              q_pop = 1'b1;
              if (!discarding) begin
                running_sum_next   = sum_closed;
                number_value_next  = '0;
                negative_flag_next = 1'b0;
                in_number_next     = 1'b0;
              end
            end
            dss_pkg::OP_DIGIT: begin
              q_pop = 1'b1;
              if (!discarding) begin
                number_value_next = digit_acc;
                in_number_next    = 1'b1;
              end
            end
            dss_pkg::OP_MINUS: begin
              q_pop = 1'b1;
              if (!discarding) begin
                if (!in_number) begin
                  negative_flag_next = 1'b1;
                  in_number_next     = 1'b1;
                end else begin
                  // minus inside a number: treat as a bad byte
                  number_value_next  = '0;
                  negative_flag_next = 1'b0;
                  in_number_next     = 1'b0;
                  discarding_next    = 1'b1;
                end
              end
            end
            default: begin
              // bad byte: clear the number, drop the rest of the write
              q_pop = 1'b1;
              if (!discarding) begin
                number_value_next  = '0;
                negative_flag_next = 1'b0;
                in_number_next     = 1'b0;
                discarding_next    = 1'b1;
              end
            end
          endcase
        end
      end

      dss_pkg::B_CONV: begin
        bcd_next = {bcd_adj[B-2:0], mag[W-1]};
        mag_next = {mag[W-2:0], 1'b0};
        cnt_next = cnt + 1'b1;
        if (cnt == dss_pkg::CNT_W'(W - 1)) begin
          idx_next     = dss_pkg::IDX_W'(dss_pkg::NUM_DIGITS - 1);
          started_next = 1'b0;
          state_next   = sum_neg ? dss_pkg::B_SIGN : dss_pkg::B_DIGITS;
        end
      end

      dss_pkg::B_SIGN: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_char_next  = dss_pkg::CH_MINUS;
          last_next      = 1'b0;
          empty_res_next = 1'b0;
          state_next     = dss_pkg::B_DIGITS;
        end
      end

      dss_pkg::B_DIGITS: begin
        if (top_digit != 4'd0 || started || last_digit) begin
          if (out_free) begin
            out_valid_next = 1'b1;
            out_char_next  = dss_pkg::CH_ZERO | {4'd0, top_digit};
            last_next      = last_digit;
            empty_res_next = 1'b0;
            started_next   = 1'b1;
            bcd_next       = {bcd[B-5:0], 4'd0};
            if (last_digit) begin
              already_sent_next = 1'b1;
              state_next        = dss_pkg::B_IDLE;
            end else begin
              idx_next = idx - 1'b1;
            end
          end
        end else begin
          // skip a leading zero
          bcd_next = {bcd[B-5:0], 4'd0};
          idx_next = idx - 1'b1;
        end
      end

      default: begin
        state_next = dss_pkg::B_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/decimal_stream_summer.sv =====
// ----------------------------------------------------------------------------
// decimal_stream_summer: ASCII decimal parser with running sum and formatter
// Sums signed decimal integers carried in write bytes; a read returns the sum
// as ASCII characters, and every second read returns an empty marker.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake        | Payload
//  ---------+------------------+----------------------------------
//  input    | push / full      | func[1:0], byte_in[7:0]
//  result   | empty / pop      | out_char[7:0], last, empty_res
//
//  Each write byte, end of write or read takes one transaction and one command
//  in the back end; the front classifies a byte in the same cycle it is taken.
//  A read that returns the sum takes the command, runs VALUE_WIDTH (32)
//  shift-and-add-3 steps in the converter, sends a minus sign when there is
//  one, then walks the decimal digit positions (ten, leading zeros skipped),
//  sending each character only once the result register is free; an
//  empty-marker read also waits for a free result register.
//  A four-entry command queue lets input transactions keep arriving while a
//  read is being converted; full rises only when that queue fills.
//  Reset (rst, synchronous) clears the sum, parser state, queue and the result
//  valid flag (not the result character); empty is high after reset.
//  A result not popped holds the back end at its next character, while the
//  front keeps filling the queue.
//
module decimal_stream_summer (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] func,
  input  logic [7:0] byte_in,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic       last,
  output logic       empty_res
);

  dss_pkg::cmd_t front_cmd;
  dss_pkg::cmd_t head_cmd;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;

  // Front: classify each incoming transaction into a command
  dss_front u_front (
    .push    (push),
    .q_full  (q_full),
    .func    (func),
    .byte_in (byte_in),
    .q_push  (q_push),
    .cmd     (front_cmd)
  );

  // Hold commands until the back end is free
  dss_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_cmd  (front_cmd),
    .rd      (q_pop),
    .rd_cmd  (head_cmd),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  assign full = q_full;

  // Back: advance the parser, accumulate, and format the sum on reads
  dss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_char  (out_char),
    .last      (last),
    .empty_res (empty_res)
  );

endmodule

// ===== rtl/dss_checker.sv =====
// ----------------------------------------------------------------------------
// dss_checker: port-level checks for the decimal stream summer
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module dss_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_char,
  input logic       last,
  input logic       empty_res
);

  // No result may be offered straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result offered after reset");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(last) && $stable(empty_res)))
    else $error("waiting result changed or vanished");

  // The empty marker is a lone, final NUL
  a_marker: assert property (@(posedge clk) disable iff (rst)
    (!empty && empty_res) |-> (last && out_char == dss_pkg::CH_NUL))
    else $error("malformed empty marker");

  // A sum character is a minus sign or a digit, and a minus is never final
  a_char: assert property (@(posedge clk) disable iff (rst)
    (!empty && !empty_res) |->
      ((out_char == dss_pkg::CH_MINUS && !last) ||
       (out_char >= dss_pkg::CH_ZERO && out_char <= dss_pkg::CH_NINE)))
    else $error("illegal sum character");

endmodule

bind decimal_stream_summer dss_checker u_dss_checker (
  .clk       (clk),
  .rst       (rst),
  .empty     (empty),
  .pop       (pop),
  .out_char  (out_char),
  .last      (last),
  .empty_res (empty_res)
);
